### sv/met_pkg.sv
`timescale 1ns / 1ps

package met_pkg;

  // number formats
  localparam int FRAC      = 24;
  localparam int C_W       = 32;
  localparam int Z_W       = 48;
  localparam int HALF_W    = 24;
  localparam int ACC_W     = 96;
  localparam int SQ_W      = 64;
  localparam int N_W       = 8;
  localparam int COORD_W   = 10;
  localparam int STEP_W    = 31;
  localparam int ESC_W     = 63;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 63;

  // register indexes
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_CX_MIN    = 3'd0;
  localparam cfg_idx_t CFG_CY_MIN    = 3'd1;
  localparam cfg_idx_t CFG_STEP_X    = 3'd2;
  localparam cfg_idx_t CFG_STEP_Y    = 3'd3;
  localparam cfg_idx_t CFG_ITER_MAX  = 3'd4;
  localparam cfg_idx_t CFG_ESCAPE_SQ = 3'd5;

  // register reset values
  localparam logic signed [C_W-1:0] CX_MIN_RST    = -32'sd41943040;
  localparam logic signed [C_W-1:0] CY_MIN_RST    = -32'sd33554432;
  localparam logic [STEP_W-1:0]     STEP_X_RST    = 31'd838861;
  localparam logic [STEP_W-1:0]     STEP_Y_RST    = 31'd671089;
  localparam logic [N_W-1:0]        ITER_MAX_RST  = 8'd20;
  localparam logic [ESC_W-1:0]      ESCAPE_SQ_RST = 63'd16777216000000;

  typedef struct packed {
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
  } pix_in_t;

  typedef struct packed {
    logic [COORD_W-1:0] out_col;
    logic [COORD_W-1:0] out_row;
    logic [N_W-1:0]     iterations;
    logic               inside_res;
    logic               pixel_on;
  } pix_out_t;

  // controller to datapath
  typedef struct packed {
    logic       load;
    logic       map;
    logic       sat;
    logic       snap;
    logic       abs_z;
    logic       mul;
    logic       fin;
    logic       chk;
    logic       zup;
    logic [1:0] phase;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic cont;
  } dp_stat_t;

endpackage

### sv/met_mac_lane.sv
`timescale 1ns / 1ps

// one 48x48 magnitude product, a 24x24 partial product per cycle while en is high
module met_mac_lane import met_pkg::*; (
  input  logic             clk,
  input  logic             clr,
  input  logic             en,
  input  logic [1:0]       phase,
  input  logic [Z_W-1:0]   a,
  input  logic [Z_W-1:0]   b,
  output logic [ACC_W-1:0] acc
);

  logic [HALF_W-1:0]   a_part;
  logic [HALF_W-1:0]   b_part;
  logic [2*HALF_W-1:0] pp;
  logic [ACC_W-1:0]    pp_al;

  assign a_part = phase[1] ? a[Z_W-1:HALF_W] : a[HALF_W-1:0];
  assign b_part = phase[0] ? b[Z_W-1:HALF_W] : b[HALF_W-1:0];
  assign pp     = {{HALF_W{1'b0}}, a_part} * {{HALF_W{1'b0}}, b_part};

  always_comb begin
    unique case (phase)
      2'd0:    pp_al = {{(2*HALF_W){1'b0}}, pp};
      2'd1,
      2'd2:    pp_al = {{HALF_W{1'b0}}, pp, {HALF_W{1'b0}}};
      2'd3:    pp_al = {pp, {(2*HALF_W){1'b0}}};
      default: pp_al = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (clr) begin
      acc <= '0;
    end else if (en) begin
      acc <= acc + pp_al;
    end
  end

endmodule

### sv/met_datapath.sv
`timescale 1ns / 1ps

module met_datapath import met_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  input  dp_cmd_t        cmd,
  output dp_stat_t       stat,
  input  pix_in_t        req,
  input  logic           cfg_we,
  input  cfg_idx_t       cfg_idx,
  input  logic [CFG_W-1:0] cfg_data,
  output pix_out_t       res
);

  localparam logic signed [42:0] C_HI  = 43'sd2147483647;
  localparam logic signed [42:0] C_LO  = -43'sd2147483648;
  localparam logic signed [53:0] Z_HI  = 54'sd140737488355327;
  localparam logic signed [53:0] Z_LO  = -54'sd140737488355328;
  localparam logic signed [64:0] D_HI  = 65'sh4000000000000;
  localparam logic signed [64:0] D_LO  = -65'sh4000000000000;
  localparam logic [50:0]        Q_TOP = {1'b1, 50'b0};

  function automatic logic signed [C_W-1:0] sat_c(input logic signed [42:0] v);
    logic signed [C_W-1:0] r;
    if (v > C_HI) begin
      r = C_HI[C_W-1:0];
    end else if (v < C_LO) begin
      r = C_LO[C_W-1:0];
    end else begin
      r = v[C_W-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [Z_W-1:0] sat_z(input logic signed [53:0] v);
    logic signed [Z_W-1:0] r;
    if (v > Z_HI) begin
      r = Z_HI[Z_W-1:0];
    end else if (v < Z_LO) begin
      r = Z_LO[Z_W-1:0];
    end else begin
      r = v[Z_W-1:0];
    end
    return r;
  endfunction

  // configuration
  logic signed [C_W-1:0] cx_min;
  logic signed [C_W-1:0] cy_min;
  logic [STEP_W-1:0]     step_x;
  logic [STEP_W-1:0]     step_y;
  logic [N_W-1:0]        iter_max;
  logic [ESC_W-1:0]      escape_sq;

  // pixel and point
  logic [COORD_W-1:0]    col_q;
  logic [COORD_W-1:0]    row_q;
  logic [40:0]           pcx;
  logic [40:0]           pcy;
  logic signed [C_W-1:0] cx;
  logic signed [C_W-1:0] cy;

  // iteration
  logic signed [Z_W-1:0] zx;
  logic signed [Z_W-1:0] zy;
  logic [Z_W-1:0]        mx;
  logic [Z_W-1:0]        my;
  logic                  neg;
  logic [ACC_W-1:0]      acc_xy;
  logic [ACC_W-1:0]      acc_xx;
  logic [ACC_W-1:0]      acc_yy;
  logic [SQ_W-1:0]       sx;
  logic [SQ_W-1:0]       sy;
  logic signed [52:0]    t_q;
  logic signed [51:0]    d_q;
  logic [N_W-1:0]        n;
  logic                  inside_q;
  logic                  pix_on_q;

  logic signed [42:0]    sum_cx;
  logic signed [42:0]    sum_cy;
  logic [C_W-1:0]        cy_mag;
  logic [71:0]           fl_xy;
  logic [71:0]           fl_xx;
  logic [71:0]           fl_yy;
  logic [50:0]           q;
  logic [51:0]           two_q;
  logic signed [52:0]    t_next;
  logic [64:0]           mag_sum;
  logic signed [64:0]    diff;
  logic signed [64:0]    diff_cl;
  logic signed [53:0]    sum_zx;
  logic signed [53:0]    sum_zy;

  always_ff @(posedge clk) begin
    if (rst) begin
      cx_min    <= CX_MIN_RST;
      cy_min    <= CY_MIN_RST;
      step_x    <= STEP_X_RST;
      step_y    <= STEP_Y_RST;
      iter_max  <= ITER_MAX_RST;
      escape_sq <= ESCAPE_SQ_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_CX_MIN:    cx_min    <= cfg_data[C_W-1:0];
        CFG_CY_MIN:    cy_min    <= cfg_data[C_W-1:0];
        CFG_STEP_X:    step_x    <= cfg_data[STEP_W-1:0];
        CFG_STEP_Y:    step_y    <= cfg_data[STEP_W-1:0];
        CFG_ITER_MAX:  iter_max  <= cfg_data[N_W-1:0];
        CFG_ESCAPE_SQ: escape_sq <= cfg_data[ESC_W-1:0];
        default: ;
      endcase
    end
  end

  // mapping
  assign sum_cx = 43'(cx_min) + $signed({2'b0, pcx});
  assign sum_cy = 43'(cy_min) + $signed({2'b0, pcy});
  assign cy_mag = cy[C_W-1] ? (~cy + 32'd1) : cy;

  met_mac_lane u_lane_xy (
    .clk   (clk),
    .clr   (cmd.abs_z),
    .en    (cmd.mul),
    .phase (cmd.phase),
    .a     (mx),
    .b     (my),
    .acc   (acc_xy)
  );

  met_mac_lane u_lane_xx (
    .clk   (clk),
    .clr   (cmd.abs_z),
    .en    (cmd.mul),
    .phase (cmd.phase),
    .a     (mx),
    .b     (mx),
    .acc   (acc_xx)
  );

  met_mac_lane u_lane_yy (
    .clk   (clk),
    .clr   (cmd.abs_z),
    .en    (cmd.mul),
    .phase (cmd.phase),
    .a     (my),
    .b     (my),
    .acc   (acc_yy)
  );

  // scale back by the fraction, round the cross term away from zero when negative
  assign fl_xy = acc_xy[ACC_W-1:FRAC];
  assign fl_xx = acc_xx[ACC_W-1:FRAC];
  assign fl_yy = acc_yy[ACC_W-1:FRAC];
  assign q     = (|fl_xy[71:50]) ? Q_TOP
               : fl_xy[50:0] + 51'(neg & (|acc_xy[FRAC-1:0]));
  assign two_q  = {q, 1'b0};
  assign t_next = neg ? (53'sd0 - $signed({1'b0, two_q})) : $signed({1'b0, two_q});

  // escape test and real-part difference
  assign mag_sum   = {1'b0, sx} + {1'b0, sy};
  assign stat.cont = (n < iter_max) && (mag_sum < {2'b0, escape_sq});
  assign diff      = $signed({1'b0, sx}) - $signed({1'b0, sy});
  assign diff_cl   = (diff > D_HI) ? D_HI : ((diff < D_LO) ? D_LO : diff);

  assign sum_zx = 54'(d_q) + 54'(cx);
  assign sum_zy = 54'(t_q) + 54'(cy);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      col_q <= req.col;
      row_q <= req.row;
      zx    <= '0;
      zy    <= '0;
    end
    if (cmd.map) begin
      pcx <= {31'b0, col_q} * {10'b0, step_x};
      pcy <= {31'b0, row_q} * {10'b0, step_y};
    end
    if (cmd.sat) begin
      cx <= sat_c(sum_cx);
      cy <= sat_c(sum_cy);
    end
    if (cmd.snap && (cy_mag < {2'b0, step_y[STEP_W-1:1]})) begin
      cy <= '0;
    end
    if (cmd.abs_z) begin
      mx  <= zx[Z_W-1] ? (~zx + 48'd1) : zx;
      my  <= zy[Z_W-1] ? (~zy + 48'd1) : zy;
      neg <= zx[Z_W-1] ^ zy[Z_W-1];
    end
    if (cmd.fin) begin
      sx  <= (|fl_xx[71:SQ_W]) ? '1 : fl_xx[SQ_W-1:0];
      sy  <= (|fl_yy[71:SQ_W]) ? '1 : fl_yy[SQ_W-1:0];
      t_q <= t_next;
    end
    if (cmd.chk) begin
      d_q      <= diff_cl[51:0];
      inside_q <= (n == iter_max);
      pix_on_q <= (n != iter_max) & n[0];
    end
    if (cmd.zup) begin
      zx <= sat_z(sum_zx);
      zy <= sat_z(sum_zy);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      n <= '0;
    end else if (cmd.load) begin
      n <= '0;
    end else if (cmd.zup) begin
      n <= n + 8'd1;
    end
  end

  assign res.out_col    = col_q;
  assign res.out_row    = row_q;
  assign res.iterations = n;
  assign res.inside_res = inside_q;
  assign res.pixel_on   = pix_on_q;

endmodule

### sv/met_ctrl.sv
`timescale 1ns / 1ps

module met_ctrl import met_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  output logic     busy,
  output logic     done,
  output dp_cmd_t  cmd,
  input  dp_stat_t stat
);

  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001,
    S_MAP  = 10'b0000000010,
    S_SAT  = 10'b0000000100,
    S_SNAP = 10'b0000001000,
    S_ABS  = 10'b0000010000,
    S_MUL  = 10'b0000100000,
    S_FIN  = 10'b0001000000,
    S_CHK  = 10'b0010000000,
    S_ZUP  = 10'b0100000000,
    S_DONE = 10'b1000000000
  } state_t;

  state_t     state;
  state_t     state_next;
  logic [1:0] phase;
  logic       accept;

  assign busy   = !((state == S_IDLE) || (state == S_DONE));
  assign done   = (state == S_DONE);
  assign accept = start && !busy;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (start) state_next = S_MAP;
      S_MAP:   state_next = S_SAT;
      S_SAT:   state_next = S_SNAP;
      S_SNAP:  state_next = S_ABS;
      S_ABS:   state_next = S_MUL;
      S_MUL:   if (phase == 2'd3) state_next = S_FIN;
      S_FIN:   state_next = S_CHK;
      S_CHK:   state_next = stat.cont ? S_ZUP : S_DONE;
      S_ZUP:   state_next = S_ABS;
      S_DONE:  state_next = start ? S_MAP : S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      phase <= '0;
    end else begin
      state <= state_next;
      phase <= (state == S_MUL) ? phase + 2'd1 : 2'd0;
    end
  end

  assign cmd.load  = accept;
  assign cmd.map   = (state == S_MAP);
  assign cmd.sat   = (state == S_SAT);
  assign cmd.snap  = (state == S_SNAP);
  assign cmd.abs_z = (state == S_ABS);
  assign cmd.mul   = (state == S_MUL);
  assign cmd.fin   = (state == S_FIN);
  assign cmd.chk   = (state == S_CHK);
  assign cmd.zup   = (state == S_ZUP);
  assign cmd.phase = phase;

  a_done_after_chk: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == S_CHK))
    else $error("result strobe without a finished escape test");

  a_mul_four_cycles: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN) |-> ($past(state == S_MUL, 4) && $past(state == S_ABS, 5)))
    else $error("product phase not four cycles long");

  a_accept_starts_map: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == S_MAP))
    else $error("accepted request did not start mapping");

endmodule

### sv/mandelbrot_escape_time_pixel_top.sv
`timescale 1ns / 1ps

// mandelbrot escape-time evaluator for one pixel per request. a request (col, row on req)
// is taken at a rising edge where start is high and busy is low. the pixel is mapped to
// c = (cx_min + col*step_x, cy_min + row*step_y) in signed fixed point with 24 fraction
// bits, and z = z*z + c is iterated from zero until iter_max is reached or |z|^2 is no
// longer below escape_sq. the result appears on res for exactly one cycle, marked by
// done; the receiver cannot hold it off and must capture it in that cycle. iter_max resets
// to twenty, and a new request may be accepted in the done cycle itself. the three 48x48
// products of z in each iteration run on 24x24 multiplier lanes, four partial products per
// lane. configuration registers are written through cfg_we / cfg_idx / cfg_data and must
// only be written while busy is low and no result is pending

module mandelbrot_escape_time_pixel_top import met_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  // request side
  input  logic             start,
  output logic             busy,
  input  pix_in_t          req,
  // configuration write port
  input  logic             cfg_we,
  input  cfg_idx_t         cfg_idx,
  input  logic [CFG_W-1:0] cfg_data,
  // result side
  output logic             done,
  output pix_out_t         res
);

  // command and status between the sequencer and the arithmetic
  dp_cmd_t  cmd;
  dp_stat_t stat;

  // sequencer: mapping, then per iteration abs, four product phases, scale, test, update
  met_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd),
    .stat  (stat)
  );

  // arithmetic, configuration registers and result registers
  met_datapath u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .stat     (stat),
    .req      (req),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .res      (res)
  );

endmodule

### tb/mandelbrot_escape_time_pixel_top_tb.sv
`timescale 1ns / 1ps

module mandelbrot_escape_time_pixel_top_tb;
  import met_pkg::*;

  // fixed point bounds used by the escape-time predictor
  localparam longint C_LO   = -64'sd2147483648;
  localparam longint C_HI   = 64'sd2147483647;
  localparam longint Z_LO   = -(64'sd1 <<< 47);
  localparam longint Z_HI   = (64'sd1 <<< 47) - 64'sd1;
  localparam logic [63:0] Z_CLAMP = 64'd1 << 50;
  localparam int MAX_ITER   = 255;
  localparam logic [ESC_W-1:0] ESC_FOUR = 63'd67108864;  // radius two, squared

  // run length: roughly 1450 requests, the watchdog sits well above the slowest run
  localparam int ITEM_TARGET = 1450;
  localparam int unsigned CYCLE_LIMIT = 3000000;
  localparam int SHOW_LIMIT = 10;

  typedef enum {WIN_CLASSIC, WIN_EXTREME, WIN_DEEP} window_kind_t;

  // saturating helpers for the escape-time arithmetic
  function automatic longint clamp(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic logic [63:0] magnitude(longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic logic [63:0] sat_sum(logic [63:0] a, logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? '1 : s[63:0];
  endfunction

  // a*b scaled down by the fraction bits, floor or ceiling, saturated to 64 bits
  function automatic logic [63:0] scaled_product(logic [63:0] a, logic [63:0] b,
                                                 bit round_up);
    logic [127:0] p;
    logic [127:0] r;
    p = {64'd0, a} * {64'd0, b};
    r = p >> FRAC;
    if (round_up && p[FRAC-1:0] != '0) r = r + 128'd1;
    return (r[127:64] != '0) ? '1 : r[63:0];
  endfunction

  // holds the register mirror and the pixels still owed by the block
  class escape_checker;
    logic signed [C_W-1:0] cx_min;
    logic signed [C_W-1:0] cy_min;
    logic [STEP_W-1:0]     step_x;
    logic [STEP_W-1:0]     step_y;
    logic [N_W-1:0]        iter_max;
    logic [ESC_W-1:0]      escape_sq;
    pix_out_t              owed_pixels[$];
    int errors;
    int n_results;
    int n_inside;
    int n_on;
    int top_iter;

    function new();
      cx_min    = CX_MIN_RST;
      cy_min    = CY_MIN_RST;
      step_x    = STEP_X_RST;
      step_y    = STEP_Y_RST;
      iter_max  = ITER_MAX_RST;
      escape_sq = ESCAPE_SQ_RST;
      errors    = 0;
      n_results = 0;
      n_inside  = 0;
      n_on      = 0;
      top_iter  = 0;
    endfunction

    function void set_reg(cfg_idx_t idx, logic [CFG_W-1:0] v);
      case (idx)
        CFG_CX_MIN:    cx_min    = v[C_W-1:0];
        CFG_CY_MIN:    cy_min    = v[C_W-1:0];
        CFG_STEP_X:    step_x    = v[STEP_W-1:0];
        CFG_STEP_Y:    step_y    = v[STEP_W-1:0];
        CFG_ITER_MAX:  iter_max  = v[N_W-1:0];
        CFG_ESCAPE_SQ: escape_sq = v[ESC_W-1:0];
        default: ;
      endcase
    endfunction

    function pix_out_t escape_time(pix_in_t p);
      longint cx, cy, zx, zy, t, zx_next, zy_next;
      logic [63:0] sx, sy, q, d;
      int n, lim;
      bit neg;
      pix_out_t r;
      cx = clamp(longint'(cx_min) + longint'(p.col) * longint'(step_x), C_LO, C_HI);
      cy = clamp(longint'(cy_min) + longint'(p.row) * longint'(step_y), C_LO, C_HI);
      // rows close to the real axis land on it exactly
      if (magnitude(cy) < 64'(step_y >> 1)) cy = 0;
      lim = (int'(iter_max) < MAX_ITER) ? int'(iter_max) : MAX_ITER;
      zx = 0;
      zy = 0;
      sx = '0;
      sy = '0;
      n  = 0;
      while (n < lim && sat_sum(sx, sy) < {1'b0, escape_sq}) begin
        // imaginary part: twice the cross product, rounded towards minus infinity
        neg = (zx < 0) != (zy < 0);
        q = scaled_product(magnitude(zx), magnitude(zy), neg);
        if (q > Z_CLAMP) q = Z_CLAMP;
        t = 2 * longint'(q);
        if (neg) t = -t;
        zy_next = clamp(t + cy, Z_LO, Z_HI);
        // real part from the squares of the old z
        if (sx >= sy) begin
          d = sx - sy;
          if (d > Z_CLAMP) d = Z_CLAMP;
          t = longint'(d);
        end else begin
          d = sy - sx;
          if (d > Z_CLAMP) d = Z_CLAMP;
          t = -longint'(d);
        end
        zx_next = clamp(t + cx, Z_LO, Z_HI);
        zx = zx_next;
        zy = zy_next;
        sx = scaled_product(magnitude(zx), magnitude(zx), 1'b0);
        sy = scaled_product(magnitude(zy), magnitude(zy), 1'b0);
        n++;
      end
      r.out_col    = p.col;
      r.out_row    = p.row;
      r.iterations = n[N_W-1:0];
      r.inside_res = (n == lim);
      r.pixel_on   = (n != lim) && n[0];
      return r;
    endfunction

    function void note_request(pix_in_t p);
      owed_pixels.push_back(escape_time(p));
    endfunction

    function void check_result(pix_out_t got);
      pix_out_t want;
      if (owed_pixels.size() == 0) begin
        errors++;
        if (errors <= SHOW_LIMIT)
          $display("unexpected result: pixel (%0d,%0d) iter %0d inside %0b on %0b",
                   got.out_col, got.out_row, got.iterations, got.inside_res, got.pixel_on);
        return;
      end
      want = owed_pixels.pop_front();
      n_results++;
      if (want.inside_res) n_inside++;
      if (want.pixel_on) n_on++;
      if (int'(want.iterations) > top_iter) top_iter = int'(want.iterations);
      if (got.out_col !== want.out_col || got.out_row !== want.out_row ||
          got.iterations !== want.iterations || got.inside_res !== want.inside_res ||
          got.pixel_on !== want.pixel_on) begin
        errors++;
        if (errors <= SHOW_LIMIT)
          $display({"mismatch: want (%0d,%0d) iter %0d inside %0b on %0b, ",
                    "got (%0d,%0d) iter %0d inside %0b on %0b"},
                   want.out_col, want.out_row, want.iterations, want.inside_res,
                   want.pixel_on, got.out_col, got.out_row, got.iterations,
                   got.inside_res, got.pixel_on);
      end
    endfunction

    function int pending();
      return owed_pixels.size();
    endfunction
  endclass

  logic             clk;
  logic             rst;
  logic             start;
  logic             busy;
  pix_in_t          req;
  logic             cfg_we;
  cfg_idx_t         cfg_idx;
  logic [CFG_W-1:0] cfg_data;
  logic             done;
  pix_out_t         res;

  escape_checker sb;
  int unsigned   cycles;
  int            sent;
  int            settings;
  bit            gaps_on;

  mandelbrot_escape_time_pixel_top dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .req      (req),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .done     (done),
    .res      (res)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // watchdog: a hung handshake or a lost result ends the run here
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still owed", cycles, sb.pending());
      $display("end of test: mismatches");
      $finish;
    end
  end

  // results last a single cycle and cannot be held off, so every done is taken
  always @(posedge clk) begin
    if (!rst && done === 1'b1 && sb != null) sb.check_result(res);
  end

  // one request: optional idle gap, then hold start until the block takes it
  task automatic send_pixel(input pix_in_t p);
    if (gaps_on && $urandom_range(0, 99) < 12) begin
      @(negedge clk);
      start = 1'b0;
      repeat ($urandom_range(0, 4)) @(negedge clk);
    end
    @(negedge clk);
    start = 1'b1;
    req   = p;
    do @(posedge clk); while (busy !== 1'b0);
    sb.note_request(p);
    sent++;
  endtask

  task automatic send_at(input int c, input int r);
    pix_in_t p;
    p.col = c[COORD_W-1:0];
    p.row = r[COORD_W-1:0];
    send_pixel(p);
  endtask

  // stop issuing and wait until every owed result has come back and the block is idle
  task automatic drain();
    @(negedge clk);
    start = 1'b0;
    while (sb.pending() != 0 || busy !== 1'b0) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] v);
    @(negedge clk);
    cfg_we   = 1'b1;
    cfg_idx  = idx;
    cfg_data = v;
    sb.set_reg(idx, v);
    @(negedge clk);
    cfg_we   = 1'b0;
  endtask

  // all six registers, only ever called with the block drained
  task automatic set_window(input logic signed [C_W-1:0] cxm, input logic signed [C_W-1:0] cym,
                            input logic [STEP_W-1:0] sx, input logic [STEP_W-1:0] sy,
                            input logic [N_W-1:0] im, input logic [ESC_W-1:0] esc);
    write_reg(CFG_CX_MIN, {31'd0, cxm});
    write_reg(CFG_CY_MIN, {31'd0, cym});
    write_reg(CFG_STEP_X, {32'd0, sx});
    write_reg(CFG_STEP_Y, {32'd0, sy});
    write_reg(CFG_ITER_MAX, {55'd0, im});
    write_reg(CFG_ESCAPE_SQ, esc);
    settings++;
  endtask

  function automatic logic [C_W-1:0] pick_coord();
    case ($urandom_range(0, 3))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [STEP_W-1:0] pick_step();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return '1;
      2: return STEP_W'($urandom_range(0, 200000));
      default: return STEP_W'($urandom);
    endcase
  endfunction

  function automatic logic [ESC_W-1:0] pick_escape();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return ESC_FOUR;
      4, 5:       return ESCAPE_SQ_RST;
      6, 7:       return ESC_W'(raw >> $urandom_range(1, 40));
      8:          return '1;
      default:    return '0;
    endcase
  endfunction

  task automatic random_setting(input window_kind_t kind);
    logic signed [C_W-1:0] cxm;
    logic signed [C_W-1:0] cym;
    logic [STEP_W-1:0]     sx;
    logic [STEP_W-1:0]     sy;
    logic [N_W-1:0]        im;
    logic [ESC_W-1:0]      esc;
    case (kind)
      WIN_CLASSIC: begin
        // a view somewhere over the usual set, a few units wide
        cxm = $urandom_range(0, 50331648) - 41943040;
        cym = $urandom_range(0, 33554432) - 33554432;
        sx  = STEP_W'($urandom_range(1000, 60000));
        sy  = STEP_W'($urandom_range(1000, 60000));
        im  = N_W'($urandom_range(1, 40));
        esc = pick_escape();
      end
      WIN_EXTREME: begin
        // anything the coordinate and step registers hold, saturation of c and z included
        cxm = pick_coord();
        cym = pick_coord();
        sx  = pick_step();
        sy  = pick_step();
        im  = N_W'($urandom_range(0, 24));
        esc = pick_escape();
      end
      default: begin
        // tight zoom near the boundary where counts run long
        cxm = $urandom_range(0, 2097152) - 13631488;
        cym = $urandom_range(0, 2097152) + 629146;
        sx  = STEP_W'($urandom_range(64, 1024));
        sy  = STEP_W'($urandom_range(64, 1024));
        im  = N_W'($urandom_range(200, 255));
        esc = ESC_FOUR;
      end
    endcase
    set_window(cxm, cym, sx, sy, im, esc);
  endtask

  initial begin
    int phase;
    int count;
    window_kind_t kind;
    pix_in_t p;

    sb       = new();
    cycles   = 0;
    sent     = 0;
    settings = 0;
    gaps_on  = 1'b1;
    rst      = 1'b1;
    start    = 1'b0;
    req      = '0;
    cfg_we   = 1'b0;
    cfg_idx  = CFG_CX_MIN;
    cfg_data = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset window: corners, alternating bit patterns, points on and off the real axis
    send_at(0, 0);
    send_at(1023, 1023);
    send_at(0, 1023);
    send_at(1023, 0);
    send_at(50, 50);     // c close to zero, row snapped onto the axis
    send_at(40, 50);     // -0.5, stays inside
    send_at(60, 50);     // 0.5, escapes slowly
    send_at(682, 341);
    send_at(341, 682);
    send_at(30, 25);
    send_at(45, 75);

    // zero limit: no iteration at all, reported as inside
    drain();
    set_window(CX_MIN_RST, CY_MIN_RST, STEP_X_RST, STEP_Y_RST, '0, ESCAPE_SQ_RST);
    send_at(50, 50);
    send_at(0, 0);

    // zero escape radius: nothing iterates, never inside
    drain();
    set_window(CX_MIN_RST, CY_MIN_RST, STEP_X_RST, STEP_Y_RST, 8'd5, '0);
    send_at(50, 50);
    send_at(1023, 0);

    // snap threshold: |cy| equal to half a step stays, one below it is snapped
    drain();
    set_window(32'sd5033165, -32'sd335544, '0, 31'd671089, 8'd40, ESCAPE_SQ_RST);
    send_at(0, 0);
    send_at(5, 1);
    drain();
    set_window(32'sd5033165, -32'sd335543, '0, 31'd671089, 8'd40, ESCAPE_SQ_RST);
    send_at(0, 0);

    // register extremes: c saturates, z saturates, squares saturate
    drain();
    set_window(32'sh8000_0000, 32'sh7FFF_FFFF, '1, '1, 8'd255, '1);
    send_at(0, 0);
    send_at(1023, 1023);
    send_at(1, 1);
    send_at(0, 1023);

    // random windows; every change waits for the block to drain, so the sender
    // regularly sits idle until nothing is owed
    phase = 0;
    while (sent < ITEM_TARGET) begin
      drain();
      if (phase % 6 == 5) kind = WIN_DEEP;
      else if ($urandom_range(0, 3) == 0) kind = WIN_EXTREME;
      else kind = WIN_CLASSIC;
      random_setting(kind);
      case (kind)
        WIN_DEEP:    count = 8;
        WIN_EXTREME: count = 40;
        default:     count = $urandom_range(60, 140);
      endcase
      // one long stretch of back-to-back requests
      gaps_on = (phase != 2);
      repeat (count) begin
        p.col = COORD_W'($urandom_range(0, 1023));
        p.row = COORD_W'($urandom_range(0, 1023));
        send_pixel(p);
      end
      phase++;
    end

    drain();
    // watch for stray results after the last one
    repeat (200) @(posedge clk);

    $display("covered %0d pixels over %0d register settings: %0d inside, %0d lit, deepest %0d",
             sb.n_results, settings, sb.n_inside, sb.n_on, sb.top_iter);
    $display("%0d mismatching results, %0d still owed", sb.errors, sb.pending());
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
